/* sv/conv2d_valid_window_defines.svh */
// Assertion macros for the windowed convolution block.
// Included by the top level; no other dependencies.
`ifndef CONV2D_VALID_WINDOW_DEFINES_SVH
`define CONV2D_VALID_WINDOW_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CDVW_ASSERT(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
`define CDVW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define CDVW_ASSERT(lbl, ck, rn, cond, msg)
`define CDVW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

/* sv/cdvw_pkg.sv */
// Shared types and constants for the windowed convolution block.
// No dependencies.
package cdvw_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_KERNEL = 7;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 16;
	localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS       = 38;
	localparam int SUM_BITS       = 37;
	localparam int POS_BITS       = 10;
	localparam int IDX_BITS       = 6;
	localparam int IN_DATA_BITS   = 24;
	localparam int OUT_DATA_BITS  = 64;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int WIDTH_BITS     = 11;
	localparam int HEIGHT_BITS    = 16;
	localparam int KSIZE_BITS     = 3;
	localparam int QDEPTH         = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_SIZE  = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	typedef struct packed {
		logic                        is_coef;
		logic [IDX_BITS-1:0]         coef_idx;
		logic signed [COEF_BITS-1:0] coef_val;
		logic [POS_BITS-1:0]         row;
		logic [POS_BITS-1:0]         col;
		logic                        last;
	} job_hdr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {F_IDLE, F_WIN} fstate_t;
	typedef enum logic [1:0] {B_IDLE, B_MAC, B_FLUSH, B_DONE} bstate_t;
endpackage

/* sv/cdvw_front.sv */
// Front part: accepts items, keeps the line store and the sample window, and
// queues coefficient loads and window jobs. Depends on cdvw_pkg.
module cdvw_front #(
	parameter int MAX_WIDTH  = cdvw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = cdvw_pkg::DEF_MAX_KERNEL,
	localparam int KW = $clog2(MAX_KERNEL + 1),
	localparam int TAPS = MAX_KERNEL * MAX_KERNEL
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [cdvw_pkg::IN_DATA_BITS-1:0] s_tdata, // value, coef_index
	input  logic s_tuser,                             // opcode
	input  logic [cdvw_pkg::WIDTH_BITS-1:0] width_cfg,
	input  logic [cdvw_pkg::HEIGHT_BITS-1:0] height_cfg,
	input  logic [KW-1:0] kk,
	input  cdvw_pkg::q_stat_t q_stat,
	output logic push,
	output cdvw_pkg::job_hdr_t push_hdr,
	output logic [TAPS*cdvw_pkg::SAMPLE_BITS-1:0] push_win
);
	localparam int SB = cdvw_pkg::SAMPLE_BITS;
	localparam int LINES = MAX_KERNEL > 1 ? MAX_KERNEL - 1 : 1;
	localparam int LW = LINES > 1 ? $clog2(LINES) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;
	localparam int RB = cdvw_pkg::HEIGHT_BITS;

	cdvw_pkg::fstate_t state_q, state_n;
	logic [RB-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [LW-1:0] rslot_q;
	logic signed [SB-1:0] samp_q;
	logic signed [SB-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
	logic signed [SB-1:0] win_n [MAX_KERNEL][MAX_KERNEL];
	logic signed [SB-1:0] lrd_q [LINES];
	logic [LW-1:0] slot_d [MAX_KERNEL];
	logic acc_in, rd_en, wr_en, idx_ok, emit, last, col_end, row_end;
	logic [WW-1:0] ww;
	logic [RB-1:0] hh;
	logic [RB-1:0] kk_r;

	assign acc_in = s_tvalid && s_tready;
	assign rd_en = acc_in && (s_tuser == cdvw_pkg::OP_SAMPLE);
	assign wr_en = (state_q == cdvw_pkg::F_WIN);
	assign idx_ok = 32'(s_tdata[21:16]) < 32'(TAPS);

	always_comb begin
		if (width_cfg == '0) begin
			ww = WW'(1);
		end else if (32'(width_cfg) > 32'(MAX_WIDTH)) begin
			ww = WW'(MAX_WIDTH);
		end else begin
			ww = WW'(width_cfg);
		end
		hh = (height_cfg == '0) ? RB'(1) : height_cfg;
		kk_r = RB'(kk);
	end

	assign col_end = 32'(col_q) >= 32'(ww) - 32'd1;
	assign row_end = row_q >= hh - RB'(1);
	assign last = row_end && col_end;
	assign emit = (row_q >= kk_r - RB'(1)) && (32'(col_q) >= 32'(kk) - 32'd1);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cdvw_pkg::F_IDLE: if (rd_en) state_n = cdvw_pkg::F_WIN;
			cdvw_pkg::F_WIN: state_n = cdvw_pkg::F_IDLE;
			default: state_n = cdvw_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == cdvw_pkg::F_IDLE) && !q_stat.full;
	end

	genvar gd, gl;
	generate
		for (gd = 0; gd < MAX_KERNEL; gd++) begin : g_slot
			localparam int DM = gd % LINES;
			assign slot_d[gd] = (rslot_q >= LW'(DM)) ? rslot_q - LW'(DM)
				: rslot_q + LW'(LINES - DM);
		end
		for (gl = 0; gl < LINES; gl++) begin : g_line
			logic signed [SB-1:0] lmem [MAX_WIDTH];
			always_ff @(posedge clk) begin
				if (rd_en) lrd_q[gl] <= lmem[col_q];
				if (wr_en && (rslot_q == LW'(gl))) lmem[col_q] <= samp_q;
			end
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < MAX_KERNEL; i++) begin
			for (int j = 0; j < MAX_KERNEL - 1; j++) win_n[i][j] = win_q[i][j+1];
			win_n[i][MAX_KERNEL-1] = win_q[i][MAX_KERNEL-1];
		end
		for (int d = 1; d < MAX_KERNEL; d++) begin
			win_n[MAX_KERNEL-1-d][MAX_KERNEL-1] = lrd_q[slot_d[d]];
		end
		win_n[MAX_KERNEL-1][MAX_KERNEL-1] = samp_q;
		for (int i = 0; i < MAX_KERNEL; i++) begin
			for (int j = 0; j < MAX_KERNEL; j++) begin
				push_win[(i*MAX_KERNEL+j)*SB +: SB] = win_n[i][j];
			end
		end
	end

	always_comb begin
		push_hdr = '0;
		if (state_q == cdvw_pkg::F_WIN) begin
			push = emit;
			push_hdr.row = cdvw_pkg::POS_BITS'(row_q - (kk_r - RB'(1)));
			push_hdr.col = cdvw_pkg::POS_BITS'(32'(col_q) - (32'(kk) - 32'd1));
			push_hdr.last = last;
		end else begin
			push = acc_in && (s_tuser == cdvw_pkg::OP_COEF) && idx_ok;
			push_hdr.is_coef = 1'b1;
			push_hdr.coef_idx = s_tdata[21:16];
			push_hdr.coef_val = s_tdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdvw_pkg::F_IDLE;
			row_q <= '0;
			col_q <= '0;
			rslot_q <= '0;
			for (int i = 0; i < MAX_KERNEL; i++)
				for (int j = 0; j < MAX_KERNEL; j++) win_q[i][j] <= '0;
		end else begin
			state_q <= state_n;
			if (wr_en) begin
				win_q <= win_n;
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						rslot_q <= '0;
					end else begin
						row_q <= row_q + RB'(1);
						rslot_q <= (rslot_q == LW'(LINES - 1)) ? '0 : rslot_q + LW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) samp_q <= s_tdata[15:0];
	end
endmodule

/* sv/cdvw_queue.sv */
// Short queue of jobs between the front and back parts.
// Depends on cdvw_pkg.
module cdvw_queue #(
	parameter int WIN_BITS = 784
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cdvw_pkg::job_hdr_t push_hdr,
	input  logic [WIN_BITS-1:0] push_win,
	input  logic pop,
	output cdvw_pkg::q_stat_t q_stat,
	output cdvw_pkg::job_hdr_t head_hdr,
	output logic [WIN_BITS-1:0] head_win
);
	localparam int D = cdvw_pkg::QDEPTH;
	localparam int PW = D > 1 ? $clog2(D) : 1;
	localparam int CNW = $clog2(D + 1);

	cdvw_pkg::job_hdr_t hdr_q [D];
	logic [WIN_BITS-1:0] win_q [D];
	logic [PW-1:0] wp_q, rp_q;
	logic [CNW-1:0] cnt_q;

	assign q_stat.full = (cnt_q == CNW'(D));
	assign q_stat.empty = (cnt_q == '0);
	assign head_hdr = hdr_q[rp_q];
	assign head_win = win_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(D - 1)) ? '0 : wp_q + PW'(1);
			if (pop) rp_q <= (rp_q == PW'(D - 1)) ? '0 : rp_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CNW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CNW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			hdr_q[wp_q] <= push_hdr;
			win_q[wp_q] <= push_win;
		end
	end
endmodule

/* sv/cdvw_back.sv */
// Back part: owns the coefficient store and runs each window job through one
// shared multiply-accumulate unit. Depends on cdvw_pkg.
module cdvw_back #(
	parameter int MAX_KERNEL = cdvw_pkg::DEF_MAX_KERNEL,
	localparam int KW = $clog2(MAX_KERNEL + 1),
	localparam int TAPS = MAX_KERNEL * MAX_KERNEL
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [KW-1:0] kk,
	input  cdvw_pkg::q_stat_t q_stat,
	input  cdvw_pkg::job_hdr_t head_hdr,
	input  logic [TAPS*cdvw_pkg::SAMPLE_BITS-1:0] head_win,
	output logic pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [cdvw_pkg::OUT_DATA_BITS-1:0] m_tdata, // conv_sum, out_row, out_col
	output logic m_tlast                                // frame_last
);
	localparam int SB = cdvw_pkg::SAMPLE_BITS;
	localparam int CB = cdvw_pkg::COEF_BITS;
	localparam int AW = TAPS > 1 ? $clog2(TAPS) : 1;

	cdvw_pkg::bstate_t state_q, state_n;
	logic signed [CB-1:0] cmem [TAPS];
	logic [TAPS-1:0] cvalid_q;
	logic [KW-1:0] ki_q, kj_q;
	logic [AW-1:0] ci_q;
	logic [AW-1:0] tap_idx;
	logic signed [SB-1:0] samp_s1;
	logic signed [CB-1:0] coef_s1;
	logic cval_s1, v_s1, v_s2;
	logic signed [cdvw_pkg::PROD_BITS-1:0] prod_s2;
	logic signed [cdvw_pkg::ACC_BITS-1:0] acc_q;
	logic coef_wr, start, issue, tap_end, load_out;
	logic m_valid_q;
	logic [cdvw_pkg::OUT_DATA_BITS-1:0] m_data_q;
	logic m_last_q;

	assign tap_idx = AW'((32'(MAX_KERNEL) - 32'(kk) + 32'(ki_q)) * MAX_KERNEL
		+ (32'(MAX_KERNEL) - 32'(kk) + 32'(kj_q)));
	assign tap_end = (kj_q == kk - KW'(1)) && (ki_q == kk - KW'(1));

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			cdvw_pkg::B_IDLE:
				if (!q_stat.empty && !head_hdr.is_coef) state_n = cdvw_pkg::B_MAC;
			cdvw_pkg::B_MAC: if (tap_end) state_n = cdvw_pkg::B_FLUSH;
			cdvw_pkg::B_FLUSH: if (!v_s1 && !v_s2) state_n = cdvw_pkg::B_DONE;
			cdvw_pkg::B_DONE: if (!m_valid_q || m_tready) state_n = cdvw_pkg::B_IDLE;
			default: state_n = cdvw_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		coef_wr = (state_q == cdvw_pkg::B_IDLE) && !q_stat.empty && head_hdr.is_coef;
		start = (state_q == cdvw_pkg::B_IDLE) && !q_stat.empty && !head_hdr.is_coef;
		issue = (state_q == cdvw_pkg::B_MAC);
		load_out = (state_q == cdvw_pkg::B_DONE) && (!m_valid_q || m_tready);
		pop = coef_wr || load_out;
	end

	always_ff @(posedge clk) begin
		if (coef_wr) cmem[AW'(head_hdr.coef_idx)] <= head_hdr.coef_val;
		if (issue) begin
			coef_s1 <= cmem[ci_q];
			samp_s1 <= head_win[tap_idx*SB +: SB];
		end
		prod_s2 <= samp_s1 * (cval_s1 ? coef_s1 : CB'(0));
		if (load_out) begin
			m_data_q <= cdvw_pkg::OUT_DATA_BITS'({head_hdr.col, head_hdr.row,
				acc_q[cdvw_pkg::SUM_BITS-1:0]});
			m_last_q <= head_hdr.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdvw_pkg::B_IDLE;
			cvalid_q <= '0;
			ki_q <= '0;
			kj_q <= '0;
			ci_q <= '0;
			cval_s1 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			acc_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (coef_wr) cvalid_q[AW'(head_hdr.coef_idx)] <= 1'b1;
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue) cval_s1 <= cvalid_q[ci_q];
			if (start) begin
				ki_q <= '0;
				kj_q <= '0;
				ci_q <= '0;
				acc_q <= '0;
			end else begin
				if (issue) begin
					ci_q <= ci_q + AW'(1);
					if (kj_q == kk - KW'(1)) begin
						kj_q <= '0;
						ki_q <= ki_q + KW'(1);
					end else begin
						kj_q <= kj_q + KW'(1);
					end
				end
				if (v_s2) acc_q <= acc_q + cdvw_pkg::ACC_BITS'(prod_s2);
			end
			if (load_out) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign m_tlast = m_last_q;
endmodule

/* sv/conv2d_valid_window.sv */
// Top level of the valid-region windowed convolution: configuration
// registers, front part, job queue and back part. Depends on cdvw_pkg,
// cdvw_front, cdvw_queue, cdvw_back and conv2d_valid_window_defines.svh.
//
// Channel  Dir  Accepted when           Payload
// s_       in   s_tvalid && s_tready    tdata: value, coef_index; tuser: opcode
// m_       out  m_tvalid && m_tready    tdata: conv_sum, out_row, out_col; tlast
// cfg_     in   cfg_we                  cfg_index, cfg_data
//
// In the front part a sample goes through a line store read, then a window
// update, and no new item is taken meanwhile; a coefficient load is queued
// on acceptance. The back part runs each job tap by tap on its single multiplier.
// Reset clears counters, window, coefficient valid bits and the queue; the
// line store has no clearing pass. The queue holds two jobs, so a stalled
// output stops the front part only once both slots are taken.
`include "conv2d_valid_window_defines.svh"
module conv2d_valid_window #(
	parameter int MAX_WIDTH  = cdvw_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = cdvw_pkg::DEF_MAX_KERNEL
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [cdvw_pkg::IN_DATA_BITS-1:0] s_tdata, // value[15:0], coef_index[21:16]
	input  logic s_tuser,                             // opcode
	output logic m_tvalid,
	input  logic m_tready,
	output logic [cdvw_pkg::OUT_DATA_BITS-1:0] m_tdata, // conv_sum, out_row, out_col
	output logic m_tlast,                              // frame_last
	input  logic cfg_we,
	input  logic [cdvw_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [cdvw_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int TAPS = MAX_KERNEL * MAX_KERNEL;
	localparam int WIN_BITS = TAPS * cdvw_pkg::SAMPLE_BITS;

	logic [cdvw_pkg::WIDTH_BITS-1:0] width_q;
	logic [cdvw_pkg::HEIGHT_BITS-1:0] height_q;
	logic [cdvw_pkg::KSIZE_BITS-1:0] ksize_q;
	logic [KW-1:0] kk;
	logic push, pop;
	cdvw_pkg::job_hdr_t push_hdr, head_hdr;
	logic [WIN_BITS-1:0] push_win, head_win;
	cdvw_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= cdvw_pkg::WIDTH_BITS'(1024);
			height_q <= cdvw_pkg::HEIGHT_BITS'(1024);
			ksize_q <= cdvw_pkg::KSIZE_BITS'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cdvw_pkg::CFG_IMAGE_WIDTH: width_q <= cfg_data[cdvw_pkg::WIDTH_BITS-1:0];
				cdvw_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				cdvw_pkg::CFG_KERNEL_SIZE: ksize_q <= cfg_data[cdvw_pkg::KSIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (ksize_q == '0) kk = KW'(1);
		else if (32'(ksize_q) > 32'(MAX_KERNEL)) kk = KW'(MAX_KERNEL);
		else kk = KW'(ksize_q);
	end

	cdvw_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .width_cfg(width_q),
		.height_cfg(height_q), .kk(kk), .q_stat(q_stat), .push(push),
		.push_hdr(push_hdr), .push_win(push_win)
	);

	cdvw_queue #(.WIN_BITS(WIN_BITS)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_hdr(push_hdr),
		.push_win(push_win), .pop(pop), .q_stat(q_stat), .head_hdr(head_hdr),
		.head_win(head_win)
	);

	cdvw_back #(.MAX_KERNEL(MAX_KERNEL)) u_back (
		.clk(clk), .arst_n(arst_n), .kk(kk), .q_stat(q_stat), .head_hdr(head_hdr),
		.head_win(head_win), .pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	`CDVW_ASSERT(a_no_push_full, clk, arst_n, !(push && q_stat.full && !pop), "push into full queue")
	`CDVW_ASSERT(a_no_pop_empty, clk, arst_n, !(pop && q_stat.empty), "pop from empty queue")
	`CDVW_ASSERT_NEXT(a_pop_gives_out, clk, arst_n, pop && !head_hdr.is_coef, m_tvalid, "job popped without result")
endmodule
